/* rtl/core/assert_macros.svh */
// Assertion macros shared by the queue RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("always-true check failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/core/twq_pkg.sv */
// Package for the timed wait queue: request codes, result codes and controller states.
// Depends on nothing; used by the queue core.
`timescale 1ns / 1ps
`default_nettype none

package twq_pkg;

  // Request codes carried on req_type.
  localparam logic [1:0] REQ_PUT  = 2'd0;
  localparam logic [1:0] REQ_GET  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // Width of the result code and of the reported queue length.
  localparam int unsigned KIND_BITS = 3;
  localparam int unsigned LEN_BITS  = 7;

  // Result codes carried on result_kind.
  localparam logic [KIND_BITS-1:0] RES_PUT_OK   = 3'd0;
  localparam logic [KIND_BITS-1:0] RES_PUT_FULL = 3'd1;
  localparam logic [KIND_BITS-1:0] RES_GOT      = 3'd2;
  localparam logic [KIND_BITS-1:0] RES_EMPTY    = 3'd3;
  localparam logic [KIND_BITS-1:0] RES_TIMEOUT  = 3'd4;
  localparam logic [KIND_BITS-1:0] RES_NONE     = 3'd5;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_TICK,
    ST_END
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/twq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module twq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data is registered and updates only when re_i is set.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/timed_wait_queue_core.sv */
// Timed wait queue core: circular FIFO of thread entries held in one RAM, with timeout sweep.
// Depends on twq_pkg, twq_ram and assert_macros.svh.
// A put answers from the result register; a get reads the head entry from the RAM, then answers;
// a tick sweeps all entries held, one result per released entry (or none), the last one flagged.
// No new request is taken while a get or tick is busy; the sweep is bound by the single RAM read port.
// Reset clears the head pointer, the entry count and all control state; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module timed_wait_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned THREAD_BITS = 8,
  parameter int unsigned TIME_BITS   = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [THREAD_BITS-1:0]         thread_id_i,
  input  wire logic [TIME_BITS-1:0]           wait_limit_i,
  output logic                                result_valid_o,
  output logic [twq_pkg::KIND_BITS-1:0]       result_kind_o,
  output logic [THREAD_BITS-1:0]              out_thread_o,
  output logic [twq_pkg::LEN_BITS-1:0]        queue_length_o,
  output logic                                last_result_o
);

  localparam int unsigned AW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WORD_BITS = 1 + TIME_BITS + THREAD_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // Slot index arithmetic modulo the queue depth.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  twq_pkg::state_e state_q, state_d;

  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          scan_n_q, scan_n_d;
  logic [CW-1:0]          rd_idx_q, rd_idx_d;
  logic [CW-1:0]          keep_q, keep_d;
  logic                   rv_q, rv_d;
  logic                   pend_q, pend_d;
  logic [THREAD_BITS-1:0] pend_thr_q, pend_thr_d;
  logic [CW-1:0]          pend_len_q, pend_len_d;

  logic                          res_valid_q, res_valid_d;
  logic [twq_pkg::KIND_BITS-1:0] res_kind_q, res_kind_d;
  logic [THREAD_BITS-1:0]        res_thr_q, res_thr_d;
  logic [CW-1:0]                 res_len_q, res_len_d;
  logic                          res_last_q, res_last_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                   rd_lim;
  logic [TIME_BITS-1:0]   rd_rem, rd_dec;
  logic [THREAD_BITS-1:0] rd_thr;
  logic                   rd_gone;
  logic                   accept;

  assign accept = start && !busy;
  assign busy   = (state_q != twq_pkg::ST_IDLE);

  // Entry storage.
  twq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Unpack the entry read last cycle and work out its decremented time.
  assign rd_thr  = ram_rdata[THREAD_BITS-1:0];
  assign rd_rem  = ram_rdata[THREAD_BITS +: TIME_BITS];
  assign rd_lim  = ram_rdata[WORD_BITS-1];
  assign rd_dec  = rd_rem - TIME_BITS'(1);
  assign rd_gone = rd_lim && (rd_dec == '0);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      twq_pkg::ST_IDLE: begin
        if (accept && req_type_i == twq_pkg::REQ_GET && count_q != '0) begin
          state_d = twq_pkg::ST_GET;
        end else if (accept && req_type_i == twq_pkg::REQ_TICK) begin
          state_d = twq_pkg::ST_TICK;
        end
      end
      twq_pkg::ST_GET: begin
        state_d = twq_pkg::ST_IDLE;
      end
      twq_pkg::ST_TICK: begin
        if (rd_idx_q == scan_n_q) begin
          state_d = twq_pkg::ST_END;
        end
      end
      twq_pkg::ST_END: begin
        state_d = twq_pkg::ST_IDLE;
      end
      default: begin
        state_d = twq_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, memory ports and result beats.
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    scan_n_d    = scan_n_q;
    rd_idx_d    = rd_idx_q;
    keep_d      = keep_q;
    rv_d        = 1'b0;
    pend_d      = pend_q;
    pend_thr_d  = pend_thr_q;
    pend_len_d  = pend_len_q;
    res_valid_d = 1'b0;
    res_kind_d  = res_kind_q;
    res_thr_d   = res_thr_q;
    res_len_d   = res_len_q;
    res_last_d  = res_last_q;
    ram_we      = 1'b0;
    ram_waddr   = wrap_add(head_q, count_q[AW-1:0]);
    ram_wdata   = {(wait_limit_i != '0), wait_limit_i, thread_id_i};
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    unique case (state_q)
      twq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            twq_pkg::REQ_PUT: begin
              res_valid_d = 1'b1;
              res_thr_d   = '0;
              res_last_d  = 1'b1;
              if (count_q == FULL_CNT) begin
                res_kind_d = twq_pkg::RES_PUT_FULL;
                res_len_d  = count_q;
              end else begin
                ram_we     = 1'b1;
                count_d    = count_q + CW'(1);
                res_kind_d = twq_pkg::RES_PUT_OK;
                res_len_d  = count_q + CW'(1);
              end
            end
            twq_pkg::REQ_GET: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_kind_d  = twq_pkg::RES_EMPTY;
                res_thr_d   = '0;
                res_len_d   = count_q;
                res_last_d  = 1'b1;
              end else begin
                ram_re = 1'b1;
              end
            end
            twq_pkg::REQ_TICK: begin
              scan_n_d = count_q;
              rd_idx_d = '0;
              keep_d   = '0;
              pend_d   = 1'b0;
            end
            default: begin
              // Unused request code: no result, nothing changes.
            end
          endcase
        end
      end

      twq_pkg::ST_GET: begin
        res_valid_d = 1'b1;
        res_kind_d  = twq_pkg::RES_GOT;
        res_thr_d   = rd_thr;
        res_len_d   = count_q - CW'(1);
        res_last_d  = 1'b1;
        count_d     = count_q - CW'(1);
        head_d      = wrap_add(head_q, AW'(1));
      end

      twq_pkg::ST_TICK: begin
        // Read the next entry of the sweep.
        if (rd_idx_q != scan_n_q) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head_q, rd_idx_q[AW-1:0]);
          rd_idx_d  = rd_idx_q + CW'(1);
          rv_d      = 1'b1;
        end
        // Settle the entry that arrived: release it or compact it toward the head.
        if (rv_q) begin
          if (rd_gone) begin
            count_d = count_q - CW'(1);
            if (pend_q) begin
              res_valid_d = 1'b1;
              res_kind_d  = twq_pkg::RES_TIMEOUT;
              res_thr_d   = pend_thr_q;
              res_len_d   = pend_len_q;
              res_last_d  = 1'b0;
            end
            pend_d     = 1'b1;
            pend_thr_d = rd_thr;
            pend_len_d = count_q - CW'(1);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wrap_add(head_q, keep_q[AW-1:0]);
            ram_wdata = {rd_lim, (rd_lim ? rd_dec : rd_rem), rd_thr};
            keep_d    = keep_q + CW'(1);
          end
        end
      end

      twq_pkg::ST_END: begin
        // The held release, if any, is the final beat of the tick.
        res_valid_d = 1'b1;
        res_last_d  = 1'b1;
        pend_d      = 1'b0;
        if (pend_q) begin
          res_kind_d = twq_pkg::RES_TIMEOUT;
          res_thr_d  = pend_thr_q;
          res_len_d  = pend_len_q;
        end else begin
          res_kind_d = twq_pkg::RES_NONE;
          res_thr_d  = '0;
          res_len_d  = count_q;
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twq_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      scan_n_q    <= '0;
      rd_idx_q    <= '0;
      keep_q      <= '0;
      rv_q        <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      scan_n_q    <= scan_n_d;
      rd_idx_q    <= rd_idx_d;
      keep_q      <= keep_d;
      rv_q        <= rv_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_thr_q <= pend_thr_d;
    pend_len_q <= pend_len_d;
    res_kind_q <= res_kind_d;
    res_thr_q  <= res_thr_d;
    res_len_q  <= res_len_d;
    res_last_q <= res_last_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign out_thread_o   = res_thr_q;
  assign queue_length_o = twq_pkg::LEN_BITS'(res_len_q);
  assign last_result_o  = res_last_q;

  // The entry count never passes the depth.
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= FULL_CNT)
  // Compaction writes never overtake the sweep reads.
  `ASSERT_IMPL(a_keep_behind, clk_i, rst_ni, state_q == twq_pkg::ST_TICK, keep_q <= rd_idx_q)
  // No sweep work is left over once the controller is idle.
  `ASSERT_IMPL(a_idle_clean, clk_i, rst_ni, state_q == twq_pkg::ST_IDLE, !rv_q && !pend_q)
  // A get on a non-empty queue enters the get state in the next cycle.
  `ASSERT_NEXT(a_get_path, clk_i, rst_ni,
               accept && req_type_i == twq_pkg::REQ_GET && count_q != '0,
               state_q == twq_pkg::ST_GET)

endmodule

`default_nettype wire
